@@ rtl/tod_pkg.sv @@
`timescale 1ns / 1ps

package tod_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int LIMIT_BITS    = 15;
    localparam int STABLE_BITS   = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;
    localparam int ORIENT_BITS   = 3;

    typedef logic [ORIENT_BITS-1:0] t_orient;

    localparam t_orient OR_START = 3'd0;
    localparam t_orient OR_XPOS  = 3'd1;
    localparam t_orient OR_XNEG  = 3'd2;
    localparam t_orient OR_YPOS  = 3'd3;
    localparam t_orient OR_YNEG  = 3'd4;
    localparam t_orient OR_FLAT  = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_X_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Z_LIMIT      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STABLE_COUNT = 2'd3;

    localparam logic [LIMIT_BITS-1:0]  LIMIT_RST  = 15'd16384;
    localparam logic [STABLE_BITS-1:0] STABLE_RST = 8'd10;

    typedef struct packed {
        logic hit;
        logic neg;
    } t_lane_hit;

    typedef struct packed {
        t_orient orientation_now;
        logic    window_done;
        logic    changed;
    } t_result;

endpackage

@@ rtl/tod_in_if.sv @@
`timescale 1ns / 1ps

interface tod_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

@@ rtl/tod_out_if.sv @@
`timescale 1ns / 1ps

interface tod_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] orientation_now;
    logic       window_done;
    logic       changed;

    modport source (output valid, output orientation_now, output window_done,
                    output changed, input ready);
    modport sink   (input valid, input orientation_now, input window_done,
                    input changed, output ready);
endinterface

@@ rtl/tod_axis_lane.sv @@
`timescale 1ns / 1ps

module tod_axis_lane
    import tod_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [LIMIT_BITS-1:0]         i_limit,
    output t_lane_hit                     o_hit
);

    localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;

    // The most negative sample maps to its true magnitude as an unsigned value.
    assign neg = i_sample[SAMPLE_BITS-1];
    assign mag = neg ? (~i_sample + 1'b1) : i_sample;

    assign o_hit.neg = neg;
    assign o_hit.hit = CMP_BITS'(mag) > CMP_BITS'(i_limit);

endmodule

@@ rtl/tod_merge.sv @@
`timescale 1ns / 1ps

module tod_merge
    import tod_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_acc,
    input  t_lane_hit              i_hit_x,
    input  t_lane_hit              i_hit_y,
    input  t_lane_hit              i_hit_z,
    input  logic [STABLE_BITS-1:0] i_stable_count,
    output t_result                o_result
);

    localparam int NEED_BITS = (COUNT_BITS > STABLE_BITS) ? COUNT_BITS : STABLE_BITS;
    localparam logic [NEED_BITS-1:0] COUNT_MAX = NEED_BITS'({COUNT_BITS{1'b1}});

    t_orient               r_cur;
    t_orient               r_cand;
    logic [COUNT_BITS-1:0] r_pos;
    t_orient               n_cur;
    t_orient               n_cand;
    logic [COUNT_BITS-1:0] n_pos;

    t_orient               cls;
    logic [NEED_BITS-1:0]  stable_ext;
    logic [COUNT_BITS-1:0] need;
    logic                  commit;
    logic                  done;
    t_orient               commit_val;

    always_comb begin
        if (i_hit_x.hit) begin
            cls = i_hit_x.neg ? OR_XNEG : OR_XPOS;
        end else if (i_hit_y.hit) begin
            cls = i_hit_y.neg ? OR_YNEG : OR_YPOS;
        end else if (i_hit_z.hit) begin
            cls = OR_FLAT;
        end else begin
            cls = r_cur;
        end
    end

    assign stable_ext = NEED_BITS'(i_stable_count);
    assign need = (stable_ext > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                           : COUNT_BITS'(stable_ext);

    always_comb begin
        n_cur      = r_cur;
        n_cand     = r_cand;
        n_pos      = r_pos;
        commit     = 1'b0;
        done       = 1'b0;
        commit_val = r_cand;
        if (r_pos == '0) begin
            n_cand     = cls;
            commit_val = cls;
            if (need == '0) begin
                commit = 1'b1;
            end else begin
                n_pos = COUNT_BITS'(1);
            end
        end else if (cls != r_cand) begin
            done  = 1'b1;
            n_pos = '0;
        end else if (r_pos >= need) begin
            commit = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
        end
        if (commit) begin
            done  = 1'b1;
            n_cur = commit_val;
            n_pos = '0;
        end
        o_result.orientation_now = n_cur;
        o_result.window_done     = done;
        o_result.changed         = commit && (commit_val != r_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= OR_START;
            r_cand <= OR_START;
            r_pos  <= '0;
        end else if (i_acc) begin
            r_cur  <= n_cur;
            r_cand <= n_cand;
            r_pos  <= n_pos;
        end
    end

endmodule

@@ rtl/tilt_orientation_debouncer_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Carries
// i_smp     in         accel_x, accel_y, accel_z (one sample per transfer)
// o_res     out        orientation_now, window_done, changed (one per sample)
// i_cfg_*   in         register writes: x_limit, y_limit, z_limit, stable_count
//
// A sample can be taken every cycle unless the skid entry is full; the three axis
// lanes and the merge logic are combinational, and each result is then registered.
// A two-entry output buffer takes one more sample while a result is stalled.
// Reset is synchronous and active low; all but the buffer data registers reset to defaults.

module tilt_orientation_debouncer_top
    import tod_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tod_in_if.sink                   i_smp,
    tod_out_if.source                o_res
);

    logic [LIMIT_BITS-1:0]  r_x_limit;
    logic [LIMIT_BITS-1:0]  r_y_limit;
    logic [LIMIT_BITS-1:0]  r_z_limit;
    logic [STABLE_BITS-1:0] r_stable;

    t_lane_hit hit_x;
    t_lane_hit hit_y;
    t_lane_hit hit_z;
    t_result   result;
    logic      acc;
    logic      take;

    t_result r_out;
    t_result r_skid;
    logic    r_out_v;
    logic    r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= LIMIT_RST;
            r_y_limit <= LIMIT_RST;
            r_z_limit <= LIMIT_RST;
            r_stable  <= STABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_LIMIT:      r_x_limit <= i_cfg_data;
                CFG_Y_LIMIT:      r_y_limit <= i_cfg_data;
                CFG_Z_LIMIT:      r_z_limit <= i_cfg_data;
                CFG_STABLE_COUNT: r_stable  <= i_cfg_data[STABLE_BITS-1:0];
            endcase
        end
    end

    tod_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .i_sample (i_smp.accel_x),
        .i_limit  (r_x_limit),
        .o_hit    (hit_x)
    );

    tod_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .i_sample (i_smp.accel_y),
        .i_limit  (r_y_limit),
        .o_hit    (hit_y)
    );

    tod_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .i_sample (i_smp.accel_z),
        .i_limit  (r_z_limit),
        .o_hit    (hit_z)
    );

    tod_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_hit_x        (hit_x),
        .i_hit_y        (hit_y),
        .i_hit_z        (hit_z),
        .i_stable_count (r_stable),
        .o_result       (result)
    );

    assign i_smp.ready = !r_skid_v;
    assign acc         = i_smp.valid && !r_skid_v;
    assign take        = r_out_v && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= acc;
            end
        end else if (acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_v) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (acc) begin
                r_out <= result;
            end
        end else if (acc) begin
            r_skid <= result;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.orientation_now = r_out.orientation_now;
    assign o_res.window_done     = r_out.window_done;
    assign o_res.changed         = r_out.changed;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register is empty");

    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_v)
        else $error("accepted sample did not reach the output register");

    a_changed_ends_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.changed) |-> o_res.window_done)
        else $error("orientation change reported without a finished window");

    a_orient_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.orientation_now <= OR_FLAT))
        else $error("orientation code out of range");
`endif

endmodule
